// ----- sv/stereo_filtered_feedback_delay_macros.svh -----
// ----------------------------------------------------------------------------
// Stereo filtered feedback delay: assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef STEREO_FILTERED_FEEDBACK_DELAY_MACROS_SVH
`define STEREO_FILTERED_FEEDBACK_DELAY_MACROS_SVH

// check outside reset
`define SFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every edge, reset included
`define SFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg
// Types, constants and helpers for the stereo filtered feedback delay.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int DATA_W          = 16;
  localparam int KNOB_W          = 17;
  localparam int CFG_IDX_W       = 3;
  localparam int DELAY_DEPTH_DEF = 65536;
  localparam int FILTER_STEPS    = 5;

  localparam logic [KNOB_W-1:0] KNOB_ONE = 17'h10000;

  localparam logic [15:0]       LAST_INDEX_RST = 16'd4999;
  localparam logic [KNOB_W-1:0] DRIVE_RST      = 17'd58982;
  localparam logic [KNOB_W-1:0] CUTOFF_RST     = 17'd19661;
  localparam logic [KNOB_W-1:0] FEEDBACK_RST   = 17'd13107;
  localparam logic [KNOB_W-1:0] MIX_RST        = 17'd19661;

  localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIX        = 3'd4;

  typedef struct packed {
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;
  } frame_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] left_out;
    logic signed [DATA_W-1:0] right_out;
  } frame_out_t;

  typedef struct packed {
    logic               start;
    logic signed [17:0] a;
    logic [16:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [35:0] prod;
  } mul_rsp_t;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [KNOB_W-1:0] knob_clamp(input logic [KNOB_W-1:0] v);
    return (v > KNOB_ONE) ? KNOB_ONE : v;
  endfunction

endpackage

// ----- sv/sfd_mul.sv -----
// ----------------------------------------------------------------------------
// sfd_mul
// Bit-serial signed by unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module sfd_mul (
  input  logic              clk,
  input  logic              rst,
  input  sfd_pkg::mul_req_t req,
  output sfd_pkg::mul_rsp_t rsp
);

  logic               busy;
  logic               done;
  logic [4:0]         cnt;
  logic signed [17:0] a_reg;
  logic signed [18:0] hi;
  logic [16:0]        lo;
  logic signed [18:0] sum;

  always_comb begin
    sum = hi + (lo[0] ? {a_reg[17], a_reg} : 19'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd16);
      if (req.start && !busy) begin
        busy  <= 1'b1;
        cnt   <= '0;
        a_reg <= req.a;
        hi    <= '0;
        lo    <= req.b;
      end else if (busy) begin
        hi  <= sum >>> 1;
        lo  <= {sum[0], lo[16:1]};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd16) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.prod = {hi[18:0], lo};

endmodule

// ----- sv/stereo_filtered_feedback_delay.sv -----
// ----------------------------------------------------------------------------
// stereo_filtered_feedback_delay
// Per channel: overdrive, five-step one-pole lowpass, feedback delay line
// and dry/wet mix, all products formed by one shared bit-serial multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one stereo frame (left_in, right_in).
//   out_valid/out_stall/out_data return one mixed frame per input frame.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the five knob registers;
//   cfg_ready is always high, write only while no frame is in flight.
// Timing:
//   Each frame runs 22 multiplications on one bit-serial multiplier of
//   17 steps, each through ST_ISSUE and ST_WAIT; after the last one,
//   ST_OUT loads the output register and raises out_valid, and the next
//   frame is taken in ST_IDLE. One frame is in work at a time; in_stall
//   is high from acceptance until the result moves into the output
//   register.
// Reset:
//   rst (synchronous) restores the knob defaults, clears filter state and
//   tap, then sweeps both delay memories to zero, one address a cycle,
//   over all DELAY_DEPTH addresses with in_stall high.
// Stall:
//   While out_stall holds the output word, a finished frame waits and
//   in_stall stays high; the next frame is taken once the word moves on.
// ----------------------------------------------------------------------------
`include "stereo_filtered_feedback_delay_macros.svh"

module stereo_filtered_feedback_delay #(
  parameter int DELAY_DEPTH = sfd_pkg::DELAY_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sfd_pkg::frame_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sfd_pkg::frame_out_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfd_pkg::KNOB_W-1:0]        cfg_data
);

  localparam int AW = (DELAY_DEPTH > 2) ? $clog2(DELAY_DEPTH) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [2:0] OP_K2  = 3'd0;
  localparam logic [2:0] OP_C   = 3'd1;
  localparam logic [2:0] OP_DRV = 3'd2;
  localparam logic [2:0] OP_FLT = 3'd3;
  localparam logic [2:0] OP_OLD = 3'd4;
  localparam logic [2:0] OP_NEW = 3'd5;
  localparam logic [2:0] OP_DRY = 3'd6;
  localparam logic [2:0] OP_WET = 3'd7;

  logic [15:0]                 last_index;
  logic [sfd_pkg::KNOB_W-1:0]  drive;
  logic [sfd_pkg::KNOB_W-1:0]  cutoff;
  logic [sfd_pkg::KNOB_W-1:0]  feedback;
  logic [sfd_pkg::KNOB_W-1:0]  mix;

  logic [2:0]         state;
  logic [2:0]         op;
  logic               ch;
  logic [2:0]         fcnt;
  logic signed [15:0] x [2];
  logic signed [15:0] filt [2];
  logic signed [15:0] res [2];
  logic [16:0]        k2;
  logic [16:0]        coef;
  logic signed [15:0] drv_s;
  logic signed [17:0] y_work;
  logic signed [19:0] t1;
  logic [AW-1:0]      tap;
  logic [AW-1:0]      clr_addr;

  logic signed [15:0] mem_l [DELAY_DEPTH];
  logic signed [15:0] mem_r [DELAY_DEPTH];
  logic signed [15:0] rd_l;
  logic signed [15:0] rd_r;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic signed [15:0] wr_data;
  logic               wr_l;
  logic               wr_r;

  sfd_pkg::mul_req_t  mul_req;
  sfd_pkg::mul_rsp_t  mul_rsp;

  logic [AW-1:0]      last_eff;
  logic [16:0]        tap_inc;
  logic [AW-1:0]      next_tap;
  logic signed [15:0] rd_ch;
  logic signed [17:0] diff;
  logic signed [19:0] sh16;
  logic signed [19:0] sh14;
  logic signed [17:0] y_next;
  logic signed [19:0] acc_sum;
  logic [16:0]        fb_eff;
  logic [16:0]        mix_eff;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_index <= sfd_pkg::LAST_INDEX_RST;
      drive      <= sfd_pkg::DRIVE_RST;
      cutoff     <= sfd_pkg::CUTOFF_RST;
      feedback   <= sfd_pkg::FEEDBACK_RST;
      mix        <= sfd_pkg::MIX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfd_pkg::REG_LAST_INDEX: last_index <= cfg_data[15:0];
        sfd_pkg::REG_DRIVE:      drive      <= cfg_data;
        sfd_pkg::REG_CUTOFF:     cutoff     <= cfg_data;
        sfd_pkg::REG_FEEDBACK:   feedback   <= cfg_data;
        sfd_pkg::REG_MIX:        mix        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (17'({1'b0, last_index}) > 17'(DELAY_DEPTH - 1)) begin
      last_eff = AW'(DELAY_DEPTH - 1);
    end else begin
      last_eff = last_index[AW-1:0];
    end
    tap_inc  = 17'(tap) + 17'd1;
    next_tap = (tap_inc > 17'(last_eff)) ? '0 : tap_inc[AW-1:0];
  end

  always_comb begin
    fb_eff  = sfd_pkg::knob_clamp(feedback);
    mix_eff = sfd_pkg::knob_clamp(mix);
    rd_ch   = ch ? rd_r : rd_l;
    diff    = {{2{drv_s[15]}}, drv_s} - y_work;
    sh16    = mul_rsp.prod[35:16];
    sh14    = mul_rsp.prod[33:14];
    y_next  = y_work + sh16[17:0];
    acc_sum = t1 + sh16;

    mul_req.start = (state == ST_ISSUE);
    unique case (op)
      OP_K2: begin
        mul_req.a = {1'b0, sfd_pkg::knob_clamp(cutoff)};
        mul_req.b = sfd_pkg::knob_clamp(cutoff);
      end
      OP_C: begin
        mul_req.a = {1'b0, k2};
        mul_req.b = k2;
      end
      OP_DRV: begin
        mul_req.a = {{2{x[ch][15]}}, x[ch]};
        mul_req.b = sfd_pkg::knob_clamp(drive);
      end
      OP_FLT: begin
        mul_req.a = diff;
        mul_req.b = coef;
      end
      OP_OLD: begin
        mul_req.a = {{2{rd_ch[15]}}, rd_ch};
        mul_req.b = fb_eff;
      end
      OP_NEW: begin
        mul_req.a = {{2{filt[ch][15]}}, filt[ch]};
        mul_req.b = sfd_pkg::KNOB_ONE - fb_eff;
      end
      OP_DRY: begin
        mul_req.a = {{2{x[ch][15]}}, x[ch]};
        mul_req.b = sfd_pkg::KNOB_ONE - mix_eff;
      end
      OP_WET: begin
        mul_req.a = {{2{rd_ch[15]}}, rd_ch};
        mul_req.b = mix_eff;
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  sfd_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  always_comb begin
    rd_addr = (op == OP_DRY || op == OP_WET) ? next_tap : tap;
    if (state == ST_CLEAR) begin
      wr_addr = clr_addr;
      wr_data = '0;
      wr_l    = 1'b1;
      wr_r    = 1'b1;
    end else begin
      wr_addr = tap;
      wr_data = sfd_pkg::sat16(acc_sum);
      wr_l    = (state == ST_WAIT) && mul_rsp.done && (op == OP_NEW) && !ch;
      wr_r    = (state == ST_WAIT) && mul_rsp.done && (op == OP_NEW) && ch;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_l) begin
      mem_l[wr_addr] <= wr_data;
    end
    rd_l <= mem_l[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_r) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      op        <= OP_K2;
      ch        <= 1'b0;
      fcnt      <= '0;
      tap       <= '0;
      clr_addr  <= '0;
      filt[0]   <= '0;
      filt[1]   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DELAY_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            x[0]  <= in_data.left_in;
            x[1]  <= in_data.right_in;
            op    <= OP_K2;
            ch    <= 1'b0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mul_rsp.done) begin
            state <= (op == OP_WET && ch) ? ST_OUT : ST_ISSUE;
            unique case (op)
              OP_K2: begin
                k2 <= mul_rsp.prod[32:16];
                op <= OP_C;
              end
              OP_C: begin
                coef <= mul_rsp.prod[32:16];
                op   <= OP_DRV;
              end
              OP_DRV: begin
                drv_s  <= sfd_pkg::sat16(sh14);
                y_work <= {{2{filt[ch][15]}}, filt[ch]};
                fcnt   <= '0;
                op     <= OP_FLT;
              end
              OP_FLT: begin
                y_work <= y_next;
                fcnt   <= fcnt + 3'd1;
                if (fcnt == 3'(sfd_pkg::FILTER_STEPS - 1)) begin
                  filt[ch] <= sfd_pkg::sat16({{2{y_next[17]}}, y_next});
                  op       <= OP_OLD;
                end
              end
              OP_OLD: begin
                t1 <= sh16;
                op <= OP_NEW;
              end
              OP_NEW: begin
                ch <= ~ch;
                op <= ch ? OP_DRY : OP_DRV;
              end
              OP_DRY: begin
                t1 <= sh16;
                op <= OP_WET;
              end
              OP_WET: begin
                res[ch] <= sfd_pkg::sat16(acc_sum);
                ch      <= ~ch;
                op      <= ch ? OP_K2 : OP_DRY;
                if (ch) begin
                  tap <= next_tap;
                end
              end
              default: ;
            endcase
          end
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid          <= 1'b1;
            out_data.left_out  <= res[0];
            out_data.right_out <= res[1];
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SFD_ASSERT_ALWAYS(a_reset_clears, rst |=> (state == ST_CLEAR), "reset did not start clear")
  `SFD_ASSERT(a_frame_start, (in_valid && !in_stall) |=> (state == ST_ISSUE && op == OP_K2),
              "accepted frame did not start sequence")
  `SFD_ASSERT(a_mul_free, (state == ST_ISSUE) |-> !mul_rsp.busy, "multiplier busy at issue")
  `SFD_ASSERT(a_write_src, (wr_l || wr_r) |-> (state == ST_CLEAR || op == OP_NEW),
              "delay write outside clear or slot update")
  `SFD_ASSERT(a_out_load, $rose(out_valid) |-> ($past(state) == ST_OUT),
              "output raised outside result stage")

endmodule
